/* rtl/core/vvs_pkg.sv */
// Shared types, codes and reset values for the vent valve sequencer.
package vvs_pkg;

    localparam int unsigned STAGE_W = 4;
    localparam int unsigned CMD_W   = 5;
    localparam int unsigned MBAR_W  = 16;
    localparam int unsigned BR_W    = 7;
    localparam int unsigned CIDX_W  = 3;

    localparam logic [2:0] ACT_START = 3'd0;
    localparam logic [2:0] ACT_ACK   = 3'd1;
    localparam logic [2:0] ACT_PASS  = 3'd2;
    localparam logic [2:0] ACT_FAIL  = 3'd3;
    localparam logic [2:0] ACT_PRESS = 3'd4;

    localparam logic [CMD_W-1:0] CMD_NONE        = 5'd0;
    localparam logic [CMD_W-1:0] CMD_OPEN_EXH    = 5'd1;
    localparam logic [CMD_W-1:0] CMD_OPEN_SLOW   = 5'd2;
    localparam logic [CMD_W-1:0] CMD_OPEN_FLOW   = 5'd5;
    localparam logic [CMD_W-1:0] CMD_OPEN_FAST   = 5'd8;
    localparam logic [CMD_W-1:0] CMD_CLOSE_BASE  = 5'd6;
    localparam logic [CMD_W-1:0] CMD_CLOSE_FLOW  = 5'd11;
    localparam logic [CMD_W-1:0] CMD_CLOSE_FAST  = 5'd14;
    localparam logic [CMD_W-1:0] CMD_OV1_ON      = 5'd15;
    localparam logic [CMD_W-1:0] CMD_OV1_OFF     = 5'd16;
    localparam logic [CMD_W-1:0] CMD_OV2_ON      = 5'd17;
    localparam logic [CMD_W-1:0] CMD_OV2_OFF     = 5'd18;
    localparam logic [CMD_W-1:0] CMD_CLOSE_ALL   = 5'd19;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    localparam logic [1:0] ST_FAIL = 2'd3;

    localparam logic [STAGE_W-1:0] STAGE_EXH   = 4'd1;
    localparam logic [STAGE_W-1:0] STAGE_SLOW2 = 4'd2;
    localparam logic [STAGE_W-1:0] STAGE_FIRST = 4'd3;
    localparam logic [STAGE_W-1:0] STAGE_FLOW1 = 4'd8;
    localparam logic [STAGE_W-1:0] STAGE_FLOW2 = 4'd9;

    localparam logic [CIDX_W-1:0] REG_BRANCH   = 3'd0;
    localparam logic [CIDX_W-1:0] REG_ATM_HI   = 3'd1;
    localparam logic [CIDX_W-1:0] REG_ATM_LO   = 3'd2;
    localparam logic [CIDX_W-1:0] REG_FAST_HI  = 3'd3;
    localparam logic [CIDX_W-1:0] REG_FAST_LO  = 3'd4;

    localparam logic [MBAR_W-1:0] ATM_HI_RST  = 16'd1100;
    localparam logic [MBAR_W-1:0] ATM_LO_RST  = 16'd950;
    localparam logic [MBAR_W-1:0] FAST_HI_RST = 16'd1500;
    localparam logic [MBAR_W-1:0] FAST_LO_RST = 16'd500;

    typedef enum logic [15:0] {
        PH_IDLE       = 16'b0000_0000_0000_0001,
        PH_DONE       = 16'b0000_0000_0000_0010,
        PH_FAILED     = 16'b0000_0000_0000_0100,
        PH_ACK_OPEN   = 16'b0000_0000_0000_1000,
        PH_CHK_OPEN   = 16'b0000_0000_0001_0000,
        PH_PRESSURE   = 16'b0000_0000_0010_0000,
        PH_ACK_FOPEN  = 16'b0000_0000_0100_0000,
        PH_ACK_FCLOSE = 16'b0000_0000_1000_0000,
        PH_ACK_CLOSE  = 16'b0000_0001_0000_0000,
        PH_CHK_CLOSE  = 16'b0000_0010_0000_0000,
        PH_ACK_OVON   = 16'b0000_0100_0000_0000,
        PH_CHK_OVON   = 16'b0000_1000_0000_0000,
        PH_ACK_OVOFF  = 16'b0001_0000_0000_0000,
        PH_CHK_OVOFF  = 16'b0010_0000_0000_0000,
        PH_ACK_EXH    = 16'b0100_0000_0000_0000,
        PH_CHK_EXH    = 16'b1000_0000_0000_0000
    } phase_t;

    typedef struct packed {
        logic [2:0]        action;
        logic [MBAR_W-1:0] pressure_mbar;
    } vvs_in_t;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [1:0]         status;
        logic [STAGE_W-1:0] current_stage;
    } vvs_out_t;

    typedef struct packed {
        logic [BR_W-1:0]   branch_enables;
        logic [MBAR_W-1:0] atm_high_mbar;
        logic [MBAR_W-1:0] atm_low_mbar;
        logic [MBAR_W-1:0] fast_high_mbar;
        logic [MBAR_W-1:0] fast_low_mbar;
    } vvs_cfg_t;

    typedef struct packed {
        logic [STAGE_W-1:0] stage;
        phase_t             phase;
        logic               fast_open;
    } vvs_state_t;

endpackage

/* rtl/core/vvs_cfg_regs.sv */
// Configuration register file for the vent valve sequencer.
module vvs_cfg_regs
    import vvs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [CIDX_W-1:0] wr_index,
    input  logic [MBAR_W-1:0] wr_data,
    output vvs_cfg_t          cfg
);

    vvs_cfg_t cfg_reg;
    vvs_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_BRANCH:  cfg_next.branch_enables = wr_data[BR_W-1:0];
                REG_ATM_HI:  cfg_next.atm_high_mbar  = wr_data;
                REG_ATM_LO:  cfg_next.atm_low_mbar   = wr_data;
                REG_FAST_HI: cfg_next.fast_high_mbar = wr_data;
                REG_FAST_LO: cfg_next.fast_low_mbar  = wr_data;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.branch_enables <= '0;
            cfg_reg.atm_high_mbar  <= ATM_HI_RST;
            cfg_reg.atm_low_mbar   <= ATM_LO_RST;
            cfg_reg.fast_high_mbar <= FAST_HI_RST;
            cfg_reg.fast_low_mbar  <= FAST_LO_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/vvs_step.sv */
// Next-state and command logic for one sequencer event.
module vvs_step
    import vvs_pkg::*;
(
    input  vvs_state_t st,
    input  vvs_cfg_t   cfg,
    input  vvs_in_t    item,
    output vvs_state_t st_next,
    output vvs_out_t   result
);

    typedef struct packed {
        logic [STAGE_W-1:0] stage;
        phase_t             phase;
        logic [CMD_W-1:0]   cmd;
    } pick_t;

    function automatic pick_t pick_next(input logic [STAGE_W-1:0] s,
                                        input logic [BR_W-1:0]    en);
        pick_t              p;
        logic               found;
        logic [STAGE_W-1:0] ns;
        found = 1'b0;
        ns    = '0;
        for (int k = BR_W - 1; k >= 0; k--)
        begin
            if (en[k] && (STAGE_W'(k) + STAGE_FIRST > s))
            begin
                found = 1'b1;
                ns    = STAGE_W'(k) + STAGE_FIRST;
            end
        end
        if (s == '0)
        begin
            p.stage = STAGE_EXH;
            p.phase = PH_ACK_EXH;
            p.cmd   = CMD_OPEN_EXH;
        end
        else if (s == STAGE_EXH)
        begin
            p.stage = STAGE_SLOW2;
            p.phase = PH_ACK_OPEN;
            p.cmd   = CMD_OPEN_SLOW;
        end
        else if (found && s < STAGE_FLOW2)
        begin
            p.stage = ns;
            if (ns == STAGE_FLOW1)
            begin
                p.phase = PH_ACK_OVON;
                p.cmd   = CMD_OV1_ON;
            end
            else if (ns == STAGE_FLOW2)
            begin
                p.phase = PH_ACK_OVON;
                p.cmd   = CMD_OV2_ON;
            end
            else
            begin
                p.phase = PH_ACK_OPEN;
                p.cmd   = {1'b0, ns};
            end
        end
        else
        begin
            p.stage = '0;
            p.phase = PH_DONE;
            p.cmd   = CMD_CLOSE_ALL;
        end
        return p;
    endfunction

    function automatic logic [CMD_W-1:0] close_cmd(input logic [STAGE_W-1:0] s);
        logic [CMD_W-1:0] c;
        c = CMD_NONE;
        if (s inside {[STAGE_FIRST:STAGE_FIRST + 4'd4]})
        begin
            c = {1'b0, s} + CMD_CLOSE_BASE;
        end
        else if (s == STAGE_FLOW1 || s == STAGE_FLOW2)
        begin
            c = CMD_CLOSE_FLOW;
        end
        return c;
    endfunction

    pick_t            pick;
    vvs_state_t       ns;
    logic [CMD_W-1:0] cmd;
    logic             is_check;
    logic             is_atm;
    logic             is_wide;

    always_comb
    begin
        ns       = st;
        cmd      = CMD_NONE;
        is_check = st.phase inside {PH_CHK_OPEN, PH_CHK_CLOSE, PH_CHK_OVON,
                                    PH_CHK_OVOFF, PH_CHK_EXH};
        is_atm   = item.pressure_mbar < cfg.atm_high_mbar &&
                   item.pressure_mbar > cfg.atm_low_mbar;
        is_wide  = item.pressure_mbar < cfg.fast_high_mbar &&
                   item.pressure_mbar > cfg.fast_low_mbar;
        pick     = pick_next(st.stage, cfg.branch_enables);

        case (item.action)
            ACT_START:
            begin
                if (st.phase inside {PH_IDLE, PH_DONE, PH_FAILED})
                begin
                    pick         = pick_next('0, cfg.branch_enables);
                    ns.stage     = pick.stage;
                    ns.phase     = pick.phase;
                    ns.fast_open = 1'b0;
                    cmd          = pick.cmd;
                end
            end
            ACT_ACK:
            begin
                case (st.phase)
                    PH_ACK_EXH:   ns.phase = PH_CHK_EXH;
                    PH_ACK_OPEN:  ns.phase = PH_CHK_OPEN;
                    PH_ACK_FOPEN: ns.phase = PH_PRESSURE;
                    PH_ACK_FCLOSE:
                    begin
                        if (st.stage <= STAGE_SLOW2)
                        begin
                            ns.stage     = pick.stage;
                            ns.phase     = pick.phase;
                            ns.fast_open = 1'b0;
                            cmd          = pick.cmd;
                        end
                        else
                        begin
                            cmd      = close_cmd(st.stage);
                            ns.phase = PH_ACK_CLOSE;
                        end
                    end
                    PH_ACK_CLOSE: ns.phase = PH_CHK_CLOSE;
                    PH_ACK_OVON:  ns.phase = PH_CHK_OVON;
                    PH_ACK_OVOFF: ns.phase = PH_CHK_OVOFF;
                    default:      ns = st;
                endcase
            end
            ACT_PASS:
            begin
                case (st.phase)
                    PH_CHK_EXH:
                    begin
                        cmd      = CMD_OPEN_SLOW;
                        ns.phase = PH_ACK_OPEN;
                    end
                    PH_CHK_OPEN: ns.phase = PH_PRESSURE;
                    PH_CHK_CLOSE:
                    begin
                        if (st.stage == STAGE_FLOW1)
                        begin
                            cmd      = CMD_OV1_OFF;
                            ns.phase = PH_ACK_OVOFF;
                        end
                        else if (st.stage == STAGE_FLOW2)
                        begin
                            cmd      = CMD_OV2_OFF;
                            ns.phase = PH_ACK_OVOFF;
                        end
                        else
                        begin
                            ns.stage     = pick.stage;
                            ns.phase     = pick.phase;
                            ns.fast_open = 1'b0;
                            cmd          = pick.cmd;
                        end
                    end
                    PH_CHK_OVON:
                    begin
                        cmd      = CMD_OPEN_FLOW;
                        ns.phase = PH_ACK_OPEN;
                    end
                    PH_CHK_OVOFF:
                    begin
                        ns.stage     = pick.stage;
                        ns.phase     = pick.phase;
                        ns.fast_open = 1'b0;
                        cmd          = pick.cmd;
                    end
                    default: ns = st;
                endcase
            end
            ACT_FAIL:
            begin
                if (is_check)
                begin
                    cmd      = CMD_CLOSE_ALL;
                    ns.phase = PH_FAILED;
                end
            end
            ACT_PRESS:
            begin
                if (st.phase == PH_PRESSURE)
                begin
                    if (is_atm)
                    begin
                        cmd      = CMD_CLOSE_FAST;
                        ns.phase = PH_ACK_FCLOSE;
                    end
                    else if (is_wide && !st.fast_open)
                    begin
                        cmd          = CMD_OPEN_FAST;
                        ns.fast_open = 1'b1;
                        ns.phase     = PH_ACK_FOPEN;
                    end
                end
            end
            default: ns = st;
        endcase
    end

    always_comb
    begin
        st_next              = ns;
        result.command       = cmd;
        result.current_stage = ns.stage;
        case (ns.phase)
            PH_IDLE:   result.status = ST_IDLE;
            PH_DONE:   result.status = ST_DONE;
            PH_FAILED: result.status = ST_FAIL;
            default:   result.status = ST_RUN;
        endcase
    end

endmodule

/* rtl/core/vent_valve_sequencer.sv */
// Vent valve sequencer top level: input register, event step logic and result register.
// Each accepted event item yields exactly one result item carrying the valve command,
// the run status and the stage after the event. An item is captured in the input
// register and is then evaluated by combinational step logic against the sequencer
// state and written to the result register, so the block takes one item per cycle
// while the result side keeps up; a stalled result holds the input register, and the
// input side stalls only once both registers are full. Configuration writes are
// always ready and take effect at the next cycle.
module vent_valve_sequencer
    import vvs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  vvs_in_t           in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output vvs_out_t          out_item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [MBAR_W-1:0] cfg_data
);

    vvs_cfg_t   cfg;
    vvs_state_t state_reg;
    vvs_state_t state_next;
    vvs_out_t   step_result;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    vvs_in_t    s1_item_reg;
    logic       s1_fire;
    logic       in_fire;

    logic       out_valid_reg;
    logic       out_valid_next;
    vvs_out_t   out_item_reg;

    assign cfg_ready = 1'b1;

    vvs_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    vvs_step u_step (
        .st      (state_reg),
        .cfg     (cfg),
        .item    (s1_item_reg),
        .st_next (state_next),
        .result  (step_result)
    );

    assign s1_fire        = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready       = !s1_valid_reg || s1_fire;
    assign in_fire        = in_valid && in_ready;
    assign s1_valid_next  = in_fire || (s1_valid_reg && !s1_fire);
    assign out_valid_next = s1_fire || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg.stage <= '0;
            state_reg.phase <= PH_IDLE;
            state_reg.fast_open <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_fire)
        begin
            out_item_reg <= step_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_done_stage_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status == ST_DONE |-> out_item.current_stage == '0)
        else $error("finished result with nonzero stage");

    a_run_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status == ST_RUN |->
            out_item.current_stage >= STAGE_EXH && out_item.current_stage <= STAGE_FLOW2)
        else $error("running result with stage out of range");

    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid)
        else $error("evaluated item produced no result");

    a_fast_flag_set: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && step_result.command == CMD_OPEN_FAST |=> state_reg.fast_open)
        else $error("fast exhaust opened without flag");

endmodule

/* tb/vvs_event_checker.sv */
// Scoreboard for the vent valve sequencer: predicts every result item and compares it field by field.
`timescale 1ns / 100ps
module vvs_event_checker
    import vvs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  vvs_in_t           in_item,
    input  logic              out_valid,
    input  logic              out_ready,
    input  vvs_out_t          out_item,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [MBAR_W-1:0] cfg_data,
    output int                mismatches,
    output int                awaiting
);

    localparam logic [STAGE_W-1:0] STAGE_NONE = '0;

    vvs_cfg_t           regs;
    logic [STAGE_W-1:0] stage;
    phase_t             ph;
    logic               fast_open;
    vvs_out_t           expected_q[$];
    vvs_out_t           want;

    initial
    begin
        mismatches = 0;
        awaiting   = 0;
    end

    task report(input string what, input int want_v, input int got_v);
        if (mismatches < 100)
            $display("%0t ns: %s expected %0d got %0d", $time, what, want_v, got_v);
        mismatches++;
    endtask

    function logic [CMD_W-1:0] advance_stage();
        logic [STAGE_W-1:0] ns;
        fast_open = 1'b0;
        if (stage == STAGE_NONE)
        begin
            stage = STAGE_EXH;
            ph    = PH_ACK_EXH;
            return CMD_OPEN_EXH;
        end
        if (stage == STAGE_EXH)
        begin
            stage = STAGE_SLOW2;
            ph    = PH_ACK_OPEN;
            return CMD_OPEN_SLOW;
        end
        while (stage >= STAGE_SLOW2 && stage < STAGE_FLOW2)
        begin
            ns    = stage + 1'b1;
            stage = ns;
            if (regs.branch_enables[ns - STAGE_FIRST])
            begin
                if (ns == STAGE_FLOW1)
                begin
                    ph = PH_ACK_OVON;
                    return CMD_OV1_ON;
                end
                if (ns == STAGE_FLOW2)
                begin
                    ph = PH_ACK_OVON;
                    return CMD_OV2_ON;
                end
                ph = PH_ACK_OPEN;
                return CMD_W'(ns);
            end
        end
        stage = STAGE_NONE;
        ph    = PH_DONE;
        return CMD_CLOSE_ALL;
    endfunction

    function logic [1:0] run_status();
        case (ph)
            PH_IDLE:   return ST_IDLE;
            PH_DONE:   return ST_DONE;
            PH_FAILED: return ST_FAIL;
            default:   return ST_RUN;
        endcase
    endfunction

    function vvs_out_t apply_event(input vvs_in_t ev);
        logic [CMD_W-1:0] cmd;
        logic             in_check;
        vvs_out_t         r;
        cmd      = CMD_NONE;
        in_check = (ph == PH_CHK_OPEN) || (ph == PH_CHK_CLOSE) || (ph == PH_CHK_OVON) ||
                   (ph == PH_CHK_OVOFF) || (ph == PH_CHK_EXH);
        case (ev.action)
            ACT_START:
            begin
                if (ph == PH_IDLE || ph == PH_DONE || ph == PH_FAILED)
                begin
                    stage = STAGE_NONE;
                    cmd   = advance_stage();
                end
            end
            ACT_ACK:
            begin
                case (ph)
                    PH_ACK_EXH:   ph = PH_CHK_EXH;
                    PH_ACK_OPEN:  ph = PH_CHK_OPEN;
                    PH_ACK_FOPEN: ph = PH_PRESSURE;
                    PH_ACK_FCLOSE:
                    begin
                        if (stage <= STAGE_SLOW2)
                            cmd = advance_stage();
                        else
                        begin
                            cmd = (stage >= STAGE_FLOW1) ? CMD_CLOSE_FLOW
                                                         : CMD_W'(stage) + CMD_CLOSE_BASE;
                            ph  = PH_ACK_CLOSE;
                        end
                    end
                    PH_ACK_CLOSE: ph = PH_CHK_CLOSE;
                    PH_ACK_OVON:  ph = PH_CHK_OVON;
                    PH_ACK_OVOFF: ph = PH_CHK_OVOFF;
                    default: ;
                endcase
            end
            ACT_PASS:
            begin
                case (ph)
                    PH_CHK_EXH:
                    begin
                        cmd = CMD_OPEN_SLOW;
                        ph  = PH_ACK_OPEN;
                    end
                    PH_CHK_OPEN: ph = PH_PRESSURE;
                    PH_CHK_CLOSE:
                    begin
                        if (stage == STAGE_FLOW1)
                        begin
                            cmd = CMD_OV1_OFF;
                            ph  = PH_ACK_OVOFF;
                        end
                        else if (stage == STAGE_FLOW2)
                        begin
                            cmd = CMD_OV2_OFF;
                            ph  = PH_ACK_OVOFF;
                        end
                        else
                            cmd = advance_stage();
                    end
                    PH_CHK_OVON:
                    begin
                        cmd = CMD_OPEN_FLOW;
                        ph  = PH_ACK_OPEN;
                    end
                    PH_CHK_OVOFF: cmd = advance_stage();
                    default: ;
                endcase
            end
            ACT_FAIL:
            begin
                if (in_check)
                begin
                    cmd = CMD_CLOSE_ALL;
                    ph  = PH_FAILED;
                end
            end
            ACT_PRESS:
            begin
                if (ph == PH_PRESSURE)
                begin
                    if (ev.pressure_mbar < regs.atm_high_mbar &&
                        ev.pressure_mbar > regs.atm_low_mbar)
                    begin
                        cmd = CMD_CLOSE_FAST;
                        ph  = PH_ACK_FCLOSE;
                    end
                    else if (ev.pressure_mbar < regs.fast_high_mbar &&
                             ev.pressure_mbar > regs.fast_low_mbar && !fast_open)
                    begin
                        cmd       = CMD_OPEN_FAST;
                        fast_open = 1'b1;
                        ph        = PH_ACK_FOPEN;
                    end
                end
            end
            default: ;
        endcase
        r.command       = cmd;
        r.status        = run_status();
        r.current_stage = stage;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.branch_enables = '0;
            regs.atm_high_mbar  = ATM_HI_RST;
            regs.atm_low_mbar   = ATM_LO_RST;
            regs.fast_high_mbar = FAST_HI_RST;
            regs.fast_low_mbar  = FAST_LO_RST;
            stage               = STAGE_NONE;
            ph                  = PH_IDLE;
            fast_open           = 1'b0;
            expected_q.delete();
            awaiting            = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BRANCH:  regs.branch_enables = cfg_data[BR_W-1:0];
                    REG_ATM_HI:  regs.atm_high_mbar  = cfg_data;
                    REG_ATM_LO:  regs.atm_low_mbar   = cfg_data;
                    REG_FAST_HI: regs.fast_high_mbar = cfg_data;
                    REG_FAST_LO: regs.fast_low_mbar  = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                    report("result with no item pending, command", CMD_NONE, out_item.command);
                else
                begin
                    want = expected_q.pop_front();
                    if (out_item.command !== want.command)
                        report("command", want.command, out_item.command);
                    if (out_item.status !== want.status)
                        report("status", want.status, out_item.status);
                    if (out_item.current_stage !== want.current_stage)
                        report("current_stage", want.current_stage, out_item.current_stage);
                end
            end
            if (in_valid && in_ready)
                expected_q.push_back(apply_event(in_item));
            awaiting = expected_q.size();
        end
    end

endmodule

/* tb/tb_vent_valve_sequencer.sv */
// Testbench top for the vent valve sequencer: reset, register setup, event stimulus and verdict.
`timescale 1ns / 100ps
module tb_vent_valve_sequencer;
    import vvs_pkg::*;

    localparam logic [2:0] ACT_UNUSED   = 3'd7;
    localparam int         PHASES       = 8;
    localparam int         PHASE_ITEMS  = 215;
    localparam int         FLOW_BIT     = STAGE_FLOW1 - STAGE_FIRST;
    localparam int         DRAIN_LIMIT  = 20000;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    vvs_in_t           in_item   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    vvs_out_t          out_item;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CIDX_W-1:0] cfg_index = '0;
    logic [MBAR_W-1:0] cfg_data  = '0;

    int       mismatches;
    int       awaiting;
    int       sent       = 0;
    int       ready_hold = 0;
    bit       quiet      = 1'b0;
    vvs_cfg_t setting    = '{branch_enables: '0, atm_high_mbar: ATM_HI_RST,
                             atm_low_mbar: ATM_LO_RST, fast_high_mbar: FAST_HI_RST,
                             fast_low_mbar: FAST_LO_RST};

    vent_valve_sequencer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    vvs_event_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
    begin
        if (quiet)
            out_ready <= 1'b1;
        else if (ready_hold > 0)
        begin
            out_ready <= 1'b0;
            ready_hold--;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            out_ready  <= 1'b0;
            ready_hold = ($urandom_range(0, 29) == 0) ? $urandom_range(20, 80)
                                                      : $urandom_range(0, 2);
        end
        else
            out_ready <= 1'b1;
    end

    function automatic logic [MBAR_W-1:0] rand_word();
        return MBAR_W'($urandom_range(0, 65535));
    endfunction

    function automatic bit is_atm(input logic [MBAR_W-1:0] p);
        return p < setting.atm_high_mbar && p > setting.atm_low_mbar;
    endfunction

    function automatic bit is_fast(input logic [MBAR_W-1:0] p);
        return p < setting.fast_high_mbar && p > setting.fast_low_mbar;
    endfunction

    function automatic bit atm_possible();
        return int'(setting.atm_high_mbar) - int'(setting.atm_low_mbar) >= 2;
    endfunction

    function automatic logic [MBAR_W-1:0] atm_sample();
        return MBAR_W'($urandom_range(int'(setting.atm_low_mbar) + 1,
                                      int'(setting.atm_high_mbar) - 1));
    endfunction

    function automatic logic [MBAR_W-1:0] stray_sample();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return setting.atm_low_mbar;
            3: return setting.atm_high_mbar;
            4: return setting.fast_low_mbar;
            5: return setting.fast_high_mbar;
            6:
            begin
                if (int'(setting.fast_high_mbar) - int'(setting.fast_low_mbar) >= 2)
                    return MBAR_W'($urandom_range(int'(setting.fast_low_mbar) + 1,
                                                  int'(setting.fast_high_mbar) - 1));
                return rand_word();
            end
            default: return rand_word();
        endcase
    endfunction

    function automatic vvs_cfg_t pick_config(input int k);
        vvs_cfg_t c;
        int       lo;
        int       hi;
        int       flo;
        int       fhi;
        lo  = $urandom_range(0, 60000);
        hi  = lo + $urandom_range(2, 3000);
        if (hi > 65535)
            hi = 65535;
        flo = $urandom_range(0, lo);
        fhi = hi + $urandom_range(0, 4000);
        if (fhi > 65535)
            fhi = 65535;
        c.branch_enables = BR_W'($urandom_range(0, 127));
        c.atm_high_mbar  = MBAR_W'(hi);
        c.atm_low_mbar   = MBAR_W'(lo);
        c.fast_high_mbar = MBAR_W'(fhi);
        c.fast_low_mbar  = MBAR_W'(flo);
        case (k)
            0:
            begin
                c.branch_enables = '1;
                c.atm_high_mbar  = ATM_HI_RST;
                c.atm_low_mbar   = ATM_LO_RST;
                c.fast_high_mbar = FAST_HI_RST;
                c.fast_low_mbar  = FAST_LO_RST;
            end
            1:
            begin
                c.atm_high_mbar  = '1;
                c.atm_low_mbar   = '0;
                c.fast_high_mbar = '1;
                c.fast_low_mbar  = '0;
            end
            2:
            begin
                c.branch_enables = '0;
                c.atm_high_mbar  = '0;
                c.atm_low_mbar   = '0;
            end
            3:
            begin
                c.branch_enables = '1;
                c.atm_high_mbar  = '1;
                c.atm_low_mbar   = 16'hFFFD;
                c.fast_high_mbar = '1;
                c.fast_low_mbar  = '0;
            end
            4:
            begin
                c.branch_enables = '1;
                c.atm_high_mbar  = 16'd2;
                c.atm_low_mbar   = '0;
                c.fast_high_mbar = '0;
                c.fast_low_mbar  = '0;
            end
            default: ;
        endcase
        return c;
    endfunction

    task automatic send_event(input logic [2:0] act, input logic [MBAR_W-1:0] p);
        int      gap;
        vvs_in_t it;
        gap = 0;
        if (!quiet && $urandom_range(0, 1) == 1)
            gap = ($urandom_range(0, 24) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        it.action        = act;
        it.pressure_mbar = p;
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic send_ack();
        if ($urandom_range(0, 49) == 0)
            send_event(ACT_START, rand_word());
        send_event(ACT_ACK, rand_word());
    endtask

    task automatic send_check(output bit broke);
        broke = ($urandom_range(0, 39) == 0);
        send_event(broke ? ACT_FAIL : ACT_PASS, rand_word());
    endtask

    task automatic wait_for_atm(output bit broke);
        int                n;
        bit                fo;
        logic [MBAR_W-1:0] p;
        fo    = 1'b0;
        broke = !atm_possible();
        n     = $urandom_range(0, 3) + (broke ? 1 : 0);
        repeat (n)
        begin
            p = stray_sample();
            if (!is_atm(p))
            begin
                send_event(ACT_PRESS, p);
                if (is_fast(p) && !fo)
                begin
                    fo = 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        send_event(ACT_PRESS, stray_sample());
                    send_ack();
                end
            end
        end
        if (!broke)
            send_event(ACT_PRESS, atm_sample());
    endtask

    task automatic vent_stage(output bit broke);
        send_ack();
        send_check(broke);
        if (broke)
            return;
        wait_for_atm(broke);
        if (broke)
            return;
        send_ack();
    endtask

    task automatic run_sequence();
        bit broke;
        bit flow;
        send_event(ACT_START, rand_word());
        send_ack();
        send_check(broke);
        if (broke)
            return;
        vent_stage(broke);
        if (broke)
            return;
        vent_stage(broke);
        if (broke)
            return;
        for (int b = 0; b < BR_W; b++)
        begin
            if (setting.branch_enables[b])
            begin
                flow = (b >= FLOW_BIT);
                if (flow)
                begin
                    send_ack();
                    send_check(broke);
                    if (broke)
                        return;
                end
                vent_stage(broke);
                if (broke)
                    return;
                send_ack();
                send_check(broke);
                if (broke)
                    return;
                if (flow)
                begin
                    send_ack();
                    send_check(broke);
                    if (broke)
                        return;
                end
            end
        end
    endtask

    task automatic noise_burst();
        logic [2:0] act;
        repeat ($urandom_range(1, 4))
        begin
            act = ($urandom_range(0, 15) == 0) ? ACT_START : 3'($urandom_range(1, 7));
            send_event(act, stray_sample());
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (awaiting != 0)
            @(negedge clk);
    endtask

    task automatic write_config(input vvs_cfg_t c);
        for (int i = REG_BRANCH; i <= REG_FAST_LO; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= CIDX_W'(i);
            case (CIDX_W'(i))
                REG_BRANCH:  cfg_data <= MBAR_W'(c.branch_enables);
                REG_ATM_HI:  cfg_data <= c.atm_high_mbar;
                REG_ATM_LO:  cfg_data <= c.atm_low_mbar;
                REG_FAST_HI: cfg_data <= c.fast_high_mbar;
                default:     cfg_data <= c.fast_low_mbar;
            endcase
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        setting = c;
    endtask

    initial
    begin
        int goal;
        int guard;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_event(ACT_PASS, '1);
        send_event(ACT_UNUSED, '0);
        send_event(ACT_START, rand_word());
        send_event(ACT_START, rand_word());
        send_event(ACT_ACK, rand_word());
        send_event(ACT_FAIL, rand_word());
        send_event(ACT_START, rand_word());
        send_event(ACT_ACK, rand_word());
        send_event(ACT_PASS, rand_word());
        send_event(ACT_ACK, rand_word());
        send_event(ACT_PASS, rand_word());
        send_event(ACT_PRESS, 16'd0);
        send_event(ACT_PRESS, 16'hFFFF);
        send_event(ACT_PRESS, 16'd1200);
        send_event(ACT_PRESS, 16'd1000);
        send_event(ACT_ACK, rand_word());
        send_event(ACT_PRESS, 16'd1200);
        send_event(ACT_PRESS, 16'd1000);
        send_event(ACT_ACK, rand_word());
        send_event(ACT_ACK, rand_word());
        send_event(ACT_PASS, rand_word());
        send_event(ACT_PRESS, 16'd950);
        send_event(ACT_ACK, rand_word());
        send_event(ACT_PRESS, 16'd1099);
        send_event(ACT_ACK, rand_word());

        for (int k = 0; k < PHASES; k++)
        begin
            wait_idle();
            write_config(pick_config(k));
            quiet = (k == 1 || k == 5);
            goal  = sent + PHASE_ITEMS;
            while (sent < goal)
            begin
                if ($urandom_range(0, 6) == 0)
                    noise_burst();
                else
                    run_sequence();
            end
        end

        in_valid <= 1'b0;
        guard = 0;
        while (awaiting != 0 && guard < DRAIN_LIMIT)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (8) @(negedge clk);
        if (mismatches == 0 && awaiting == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #15_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/vvs_pkg.sv
rtl/core/vvs_cfg_regs.sv
rtl/core/vvs_step.sv
rtl/core/vent_valve_sequencer.sv
tb/vvs_event_checker.sv
tb/tb_vent_valve_sequencer.sv
